// ----- rtl/core/rcdm_pkg.sv -----
// Package: widths, codes and constants shared by the row difference metric files
`timescale 1ns / 1ps

package rcdm_pkg;

    // Row geometry and pixel width
    localparam int ROW_MAX    = 4096;
    localparam int PIX_W      = 16;
    localparam int LOG_ROW    = $clog2(ROW_MAX);
    localparam int CNT_W      = $clog2(ROW_MAX + 1);
    localparam int MIN_PIX    = 2;

    // Accumulator widths (never wrap for a full row)
    localparam int SUM_W      = PIX_W + LOG_ROW;
    localparam int SQ_W       = 2 * PIX_W + LOG_ROW;

    // End-of-row arithmetic
    localparam int SQ_SHIFT   = 18;
    localparam int MEAN_SHIFT = 8;
    localparam int SCALE_W    = 7;
    localparam int METRIC_SCALE = 100;
    localparam int Q1_W       = SQ_W + SQ_SHIFT;
    localparam int ROOT_W     = (Q1_W + 1) / 2;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int PROD_W     = ROOT_W + CNT_W;
    localparam int PROD2_W    = PROD_W + SCALE_W;
    localparam int MNUM_W     = SUM_W + MEAN_SHIFT;
    localparam int DEN_W      = SUM_W + 1;
    localparam int REM_W      = (DEN_W > ROOT_W + 1) ? DEN_W : ROOT_W + 1;
    localparam int TRIAL_W    = REM_W + 2;
    localparam int WORK_A_W   = (RAD_W > PROD2_W) ? RAD_W : PROD2_W;
    localparam int WORK_W     = (WORK_A_W > MNUM_W) ? WORK_A_W : MNUM_W;
    localparam int STEP_W     = $clog2(WORK_W + 1);

    // Result field widths
    localparam int METRIC_W   = 32;
    localparam int MEAN_W     = 24;
    localparam int FAULT_W    = 2;
    localparam int FMT_W      = 2;

    // Pixel format register codes
    localparam logic [FMT_W-1:0] FMT_GRAY8 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_LE16  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_BE16  = 2'd2;

    // Fault codes
    localparam logic [FAULT_W-1:0] FLT_OK    = 2'd0;
    localparam logic [FAULT_W-1:0] FLT_SHORT = 2'd1;
    localparam logic [FAULT_W-1:0] FLT_ZERO  = 2'd2;
    localparam logic [FAULT_W-1:0] FLT_LONG  = 2'd3;

    // Largest legal mean in Q8
    localparam logic [MEAN_W-1:0] MEAN_MAX = 24'hFFFF00;

endpackage

// ----- rtl/core/row_column_difference_metric.sv -----
// Top level: row neighbor-difference metric with a shared divide/square-root unit
`timescale 1ns / 1ps

// Channel     Direction  Handshake                  Payload
// pixel in    in         i_in_valid / o_in_ready    i_pixel_word, i_last_in_row
// result out  out        o_out_valid / i_out_ready  o_col_diff_q8, o_row_mean_q8, o_fault
// config      in         i_cfg_we (no wait)         i_cfg_data (pixel format)
//
// Pixels that are not last in a row are taken at one per cycle.
// A last pixel starts the end-of-row pass on one shared compare/subtract unit:
// a check, Q1_W-bit divide, ROOT_W-bit root, two multiply states, PROD2_W-bit divide,
// a metric load, an MNUM_W-bit divide and a done state; a fault goes check to done.
// The result register holds its request while i_out_ready is low; the end-of-row
// pass waits in its last state until that register is free. Reset is synchronous.

module row_column_difference_metric (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rcdm_pkg::PIX_W-1:0]    i_pixel_word,
    input  logic                          i_last_in_row,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rcdm_pkg::METRIC_W-1:0] o_col_diff_q8,
    output logic [rcdm_pkg::MEAN_W-1:0]   o_row_mean_q8,
    output logic [rcdm_pkg::FAULT_W-1:0]  o_fault,
    input  logic                          i_cfg_we,
    input  logic [rcdm_pkg::FMT_W-1:0]    i_cfg_data
);
    import rcdm_pkg::*;

    // Sequencer codes
    localparam logic [3:0] S_ACC  = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_DIV1 = 4'd2;
    localparam logic [3:0] S_SQRT = 4'd3;
    localparam logic [3:0] S_MUL1 = 4'd4;
    localparam logic [3:0] S_MUL2 = 4'd5;
    localparam logic [3:0] S_DIVM = 4'd6;
    localparam logic [3:0] S_MLD  = 4'd7;
    localparam logic [3:0] S_DIVA = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    // Control and accumulator state
    logic [3:0]          r_state, n_state;
    logic [FMT_W-1:0]    r_fmt;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [PIX_W-1:0]    r_prev, n_prev;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [SQ_W-1:0]     r_sq, n_sq;
    logic                r_ovf, n_ovf;
    logic                r_out_valid, n_out_valid;

    // Datapath registers
    logic [WORK_W-1:0]   r_work, n_work;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [DEN_W-1:0]    r_den, n_den;
    logic [ROOT_W-1:0]   r_root, n_root;
    logic [STEP_W-1:0]   r_cnt, n_cnt;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [METRIC_W-1:0] r_metric, n_metric;
    logic [FAULT_W-1:0]  r_fault, n_fault;
    logic [METRIC_W-1:0] r_o_metric, n_o_metric;
    logic [MEAN_W-1:0]   r_o_mean, n_o_mean;
    logic [FAULT_W-1:0]  r_o_fault, n_o_fault;

    // Combinational helpers
    logic                in_acc;
    logic [PIX_W-1:0]    pix;
    logic [PIX_W-1:0]    diff_abs;
    logic [2*PIX_W-1:0]  diff_sq;
    logic                sqrt_mode;
    logic [TRIAL_W-1:0]  trial, subtr, trial_diff;
    logic                trial_ge;
    logic [PROD2_W-1:0]  prod2;

    assign in_acc = i_in_valid && o_in_ready;

    // Byte order of the incoming word
    always_comb begin
        case (r_fmt)
            FMT_GRAY8: pix = {8'd0, i_pixel_word[7:0]};
            FMT_BE16:  pix = {i_pixel_word[7:0], i_pixel_word[15:8]};
            default:   pix = i_pixel_word;
        endcase
    end

    // Neighbor difference squared
    assign diff_abs = (pix >= r_prev) ? (pix - r_prev) : (r_prev - pix);
    assign diff_sq  = diff_abs * diff_abs;

    // Shared compare/subtract unit: restoring divide or digit-by-digit root
    assign sqrt_mode  = (r_state == S_SQRT);
    assign trial      = sqrt_mode ? {r_rem, r_work[WORK_W-1 -: 2]}
                                  : {1'b0, r_rem, r_work[WORK_W-1]};
    assign subtr      = sqrt_mode ? TRIAL_W'({r_root, 2'b01}) : TRIAL_W'(r_den);
    assign trial_ge   = (trial >= subtr);
    assign trial_diff = trial - subtr;

    // Scale of the root-times-count product
    assign prod2 = PROD2_W'(r_prod) * PROD2_W'(METRIC_SCALE);

    // Sequencer and datapath next state
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_prev      = r_prev;
        n_sum       = r_sum;
        n_sq        = r_sq;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_work      = r_work;
        n_rem       = r_rem;
        n_den       = r_den;
        n_root      = r_root;
        n_cnt       = r_cnt;
        n_prod      = r_prod;
        n_metric    = r_metric;
        n_fault     = r_fault;
        n_o_metric  = r_o_metric;
        n_o_mean    = r_o_mean;
        n_o_fault   = r_o_fault;

        // result taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_ACC: begin
                if (in_acc) begin
                    if (r_count >= CNT_W'(ROW_MAX)) begin
                        n_ovf = 1'b1;
                    end else begin
                        if (r_count != '0) begin
                            n_sq = r_sq + SQ_W'(diff_sq);
                        end
                        n_sum   = r_sum + SUM_W'(pix);
                        n_prev  = pix;
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_last_in_row) begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (r_ovf) begin
                    n_fault = FLT_LONG;
                    n_state = S_DONE;
                end else if (r_count < CNT_W'(MIN_PIX)) begin
                    n_fault = FLT_SHORT;
                    n_state = S_DONE;
                end else if (r_sum == '0) begin
                    n_fault = FLT_ZERO;
                    n_state = S_DONE;
                end else begin
                    // S * 2^18 / (n - 1), dividend left aligned
                    n_fault = FLT_OK;
                    n_work  = WORK_W'({r_sq, SQ_SHIFT'(0)}) << (WORK_W - Q1_W);
                    n_den   = DEN_W'(r_count - CNT_W'(1));
                    n_rem   = '0;
                    n_cnt   = STEP_W'(Q1_W);
                    n_state = S_DIV1;
                end
            end
            S_DIV1, S_DIVM, S_DIVA: begin
                n_rem  = trial_ge ? trial_diff[REM_W-1:0] : trial[REM_W-1:0];
                n_work = {r_work[WORK_W-2:0], trial_ge};
                n_cnt  = r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    case (r_state)
                        S_DIV1: begin
                            // quotient is the radicand
                            n_rem   = '0;
                            n_root  = '0;
                            n_cnt   = STEP_W'(ROOT_W);
                            n_state = S_SQRT;
                        end
                        S_DIVM:  n_state = S_MLD;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SQRT: begin
                n_rem  = trial_ge ? trial_diff[REM_W-1:0] : trial[REM_W-1:0];
                n_work = {r_work[WORK_W-3:0], 2'b00};
                n_root = {r_root[ROOT_W-2:0], trial_ge};
                n_cnt  = r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                n_prod  = PROD_W'(r_root) * PROD_W'(r_count);
                n_state = S_MUL2;
            end
            S_MUL2: begin
                // 100 * r * n / (2 * sum)
                n_work  = WORK_W'(prod2) << (WORK_W - PROD2_W);
                n_den   = {r_sum, 1'b0};
                n_rem   = '0;
                n_cnt   = STEP_W'(PROD2_W);
                n_state = S_DIVM;
            end
            S_MLD: begin
                // saturate metric, then sum * 256 / n
                n_metric = (|r_work[PROD2_W-1:METRIC_W]) ? '1 : r_work[METRIC_W-1:0];
                n_work   = WORK_W'({r_sum, MEAN_SHIFT'(0)}) << (WORK_W - MNUM_W);
                n_den    = DEN_W'(r_count);
                n_rem    = '0;
                n_cnt    = STEP_W'(MNUM_W);
                n_state  = S_DIVA;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_fault   = r_fault;
                    n_o_metric  = (r_fault == FLT_OK) ? r_metric : '0;
                    n_o_mean    = (r_fault == FLT_OK) ? r_work[MEAN_W-1:0] : '0;
                    n_count     = '0;
                    n_prev      = '0;
                    n_sum       = '0;
                    n_sq        = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_ACC;
                end
            end
            default: n_state = S_ACC;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_fmt       <= FMT_LE16;
            r_count     <= '0;
            r_prev      <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_prev      <= n_prev;
            r_sum       <= n_sum;
            r_sq        <= n_sq;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_fmt <= i_cfg_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_work     <= n_work;
        r_rem      <= n_rem;
        r_den      <= n_den;
        r_root     <= n_root;
        r_cnt      <= n_cnt;
        r_prod     <= n_prod;
        r_metric   <= n_metric;
        r_fault    <= n_fault;
        r_o_metric <= n_o_metric;
        r_o_mean   <= n_o_mean;
        r_o_fault  <= n_o_fault;
    end

    assign o_in_ready    = (r_state == S_ACC);
    assign o_out_valid   = r_out_valid;
    assign o_col_diff_q8 = r_o_metric;
    assign o_row_mean_q8 = r_o_mean;
    assign o_fault       = r_o_fault;

endmodule

// ----- rtl/core/rcdm_chk.sv -----
// Checker: port-level assertions for the row difference metric, bound to the top level
`timescale 1ns / 1ps

module rcdm_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_last_in_row,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [rcdm_pkg::METRIC_W-1:0] o_col_diff_q8,
    input logic [rcdm_pkg::MEAN_W-1:0]   o_row_mean_q8,
    input logic [rcdm_pkg::FAULT_W-1:0]  o_fault
);
    import rcdm_pkg::*;

    // A stalled result request keeps its fields
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_col_diff_q8)
            && $stable(o_row_mean_q8) && $stable(o_fault))
        else $error("result request changed while stalled");

    // A faulted row reports zero metric and mean
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_fault != FLT_OK) |-> (o_col_diff_q8 == '0)
            && (o_row_mean_q8 == '0))
        else $error("faulted result carries nonzero fields");

    // The end-of-row pass blocks input right after a last pixel
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last_in_row |=> !o_in_ready)
        else $error("input taken during end-of-row pass");

    // Mean never exceeds the largest pixel in Q8
    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_row_mean_q8 <= MEAN_MAX))
        else $error("row mean out of range");

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

endmodule

bind row_column_difference_metric rcdm_chk u_rcdm_chk (.*);

// ----- dv/testbench.sv -----
// Testbench for the row column-difference metric: queued pixel rows, running predictor, scoreboard
`timescale 1ns / 1ps

module testbench;
    import rcdm_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 3;
    localparam int CYCLE_LIMIT   = 10000000;
    localparam int DRAIN_CYCLES  = 256;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_PIXELS  = 250;

    // Format code 3 has no name in the package; the block reads it as little-endian
    localparam logic [FMT_W-1:0] FMT_LE16_ALT = 2'd3;

    typedef enum int {
        ROW_NOISE,
        ROW_NEAR,
        ROW_FLAT,
        ROW_DARK,
        ROW_EXTREME,
        ROW_ZIGZAG
    } row_style_e;

    typedef struct packed {
        logic [PIX_W-1:0] word;
        logic             last;
    } pixel_req_t;

    typedef struct packed {
        logic [METRIC_W-1:0] metric;
        logic [MEAN_W-1:0]   mean;
        logic [FAULT_W-1:0]  fault;
    } row_result_t;

    // DUT connections
    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_ready;
    logic [PIX_W-1:0]    i_pixel_word  = '0;
    logic                i_last_in_row = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready   = 1'b0;
    logic [METRIC_W-1:0] o_col_diff_q8;
    logic [MEAN_W-1:0]   o_row_mean_q8;
    logic [FAULT_W-1:0]  o_fault;
    logic                i_cfg_we      = 1'b0;
    logic [FMT_W-1:0]    i_cfg_data    = '0;

    // Stimulus and scoreboard
    pixel_req_t  pixel_backlog[$];
    row_result_t rows_due[$];
    logic        pixel_taken   = 1'b0;
    int          fails         = 0;
    int unsigned cycle_count   = 0;
    int unsigned gap_pct       = 0;
    int unsigned stall_pct     = 0;
    int unsigned gap_left      = 0;
    int unsigned stall_left    = 0;
    int unsigned hold_left     = 0;
    logic        hold_request  = 1'b0;
    logic        hold_served   = 1'b0;

    // Predictor state: row accumulators and the format register copy
    logic [FMT_W-1:0] row_fmt     = FMT_LE16;
    int unsigned      row_len     = 0;
    logic [PIX_W-1:0] prev_pix    = '0;
    logic [63:0]      row_sum     = '0;
    logic [63:0]      diff_sq_sum = '0;
    logic             row_overrun = 1'b0;

    row_column_difference_metric DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel_word  (i_pixel_word),
        .i_last_in_row (i_last_in_row),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_col_diff_q8 (o_col_diff_q8),
        .o_row_mean_q8 (o_row_mean_q8),
        .o_fault       (o_fault),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Integer square root, one result bit per pass
    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    // Fold one accepted pixel into the row; on the last pixel queue the row result
    function automatic void accumulate_pixel(input logic [PIX_W-1:0] word, input logic last);
        logic [PIX_W-1:0] pix;
        logic [63:0]      step;
        logic [63:0]      root;
        logic [63:0]      metric;
        row_result_t      res;
        case (row_fmt)
            FMT_GRAY8: pix = {8'h00, word[7:0]};
            FMT_BE16:  pix = {word[7:0], word[15:8]};
            default:   pix = word;
        endcase
        // past the maximum width pixels are dropped and the row is marked
        if (row_len >= ROW_MAX) begin
            row_overrun = 1'b1;
        end else begin
            if (row_len != 0) begin
                step = (pix >= prev_pix) ? 64'(pix - prev_pix) : 64'(prev_pix - pix);
                diff_sq_sum += step * step;
            end
            row_sum += 64'(pix);
            prev_pix = pix;
            row_len++;
        end
        if (last) begin
            res = '0;
            // overrun wins over short row, short row over zero mean
            if (row_overrun) begin
                res.fault = FLT_LONG;
            end else if (row_len < MIN_PIX) begin
                res.fault = FLT_SHORT;
            end else if (row_sum == 0) begin
                res.fault = FLT_ZERO;
            end else begin
                res.fault = FLT_OK;
                root = floor_root((diff_sq_sum << SQ_SHIFT) / 64'(row_len - 1));
                res.mean = MEAN_W'((row_sum << MEAN_SHIFT) / 64'(row_len));
                metric = (64'(METRIC_SCALE) * root * 64'(row_len)) / (2 * row_sum);
                res.metric = (metric > 64'hFFFF_FFFF) ? {METRIC_W{1'b1}} : metric[METRIC_W-1:0];
            end
            rows_due.push_back(res);
            row_len     = 0;
            prev_pix    = '0;
            row_sum     = '0;
            diff_sq_sum = '0;
            row_overrun = 1'b0;
        end
    endfunction

    // Input side: track requests taken, predict, and check results
    always @(posedge i_clk) begin
        row_result_t want;
        pixel_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            accumulate_pixel(i_pixel_word, i_last_in_row);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rows_due.size() == 0) begin
                $error("unexpected result: col_diff_q8 %0d row_mean_q8 %0d fault %0d",
                       o_col_diff_q8, o_row_mean_q8, o_fault);
                fails++;
            end else begin
                want = rows_due.pop_front();
                if (o_col_diff_q8 !== want.metric) begin
                    $error("col_diff_q8: expected %0d, got %0d", want.metric, o_col_diff_q8);
                    fails++;
                end
                if (o_row_mean_q8 !== want.mean) begin
                    $error("row_mean_q8: expected %0d, got %0d", want.mean, o_row_mean_q8);
                    fails++;
                end
                if (o_fault !== want.fault) begin
                    $error("fault: expected %0d, got %0d", want.fault, o_fault);
                    fails++;
                end
            end
        end
    end

    // Pixel driver: pops the backlog, inserts random gaps after taken requests
    always @(negedge i_clk) begin
        pixel_req_t nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || pixel_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pixel_taken && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
                gap_left = $urandom_range(0, 9);
                i_in_valid <= 1'b0;
            end else if (pixel_backlog.size() != 0) begin
                nxt = pixel_backlog.pop_front();
                i_in_valid    <= 1'b1;
                i_pixel_word  <= nxt.word;
                i_last_in_row <= nxt.last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stall bursts plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            hold_left   = LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 9);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic queue_pixel(input logic [PIX_W-1:0] word, input logic last);
        pixel_req_t p;
        p.word = word;
        p.last = last;
        pixel_backlog.push_back(p);
    endtask

    task automatic queue_row(input int unsigned len, input row_style_e style);
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] word;
        int unsigned      k;
        base = PIX_W'($urandom);
        for (k = 0; k < len; k++) begin
            case (style)
                ROW_NEAR:    word = base + PIX_W'($urandom_range(0, 31));
                ROW_FLAT:    word = base;
                ROW_DARK:    word = '0;
                ROW_EXTREME: word = $urandom_range(0, 1) ? '1 : '0;
                ROW_ZIGZAG:  word = k[0] ? '1 : '0;
                default:     word = PIX_W'($urandom);
            endcase
            queue_pixel(word, k == len - 1);
        end
    endtask

    // Wait until every pixel is taken, every row checked, and the block is quiet
    task automatic drain();
        while (pixel_backlog.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (rows_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_format(input logic [FMT_W-1:0] fmt);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= fmt;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        row_fmt = fmt;
    endtask

    // Stimulus sequence
    initial begin
        int unsigned      ph;
        int unsigned      fill;
        int unsigned      len;
        row_style_e       style;
        logic [FMT_W-1:0] fmt;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        gap_pct   = 20;
        stall_pct = 20;

        // Reset format: single pixel, dark row, extremes, alternating bits
        queue_pixel(16'h1234, 1'b1);
        queue_pixel(16'h0000, 1'b0);
        queue_pixel(16'h0000, 1'b1);
        queue_pixel(16'hFFFF, 1'b0);
        queue_pixel(16'h0000, 1'b1);
        queue_pixel(16'h0000, 1'b0);
        queue_pixel(16'hFFFF, 1'b0);
        queue_pixel(16'hFFFF, 1'b1);
        queue_pixel(16'h5555, 1'b0);
        queue_pixel(16'hAAAA, 1'b1);
        drain();

        // Gray: high byte ignored, so a high-byte-only row has zero mean
        set_format(FMT_GRAY8);
        queue_pixel(16'hAB00, 1'b0);
        queue_pixel(16'hCD00, 1'b1);
        queue_pixel(16'h00FF, 1'b0);
        queue_pixel(16'hFF01, 1'b0);
        queue_pixel(16'h1280, 1'b1);
        drain();

        set_format(FMT_BE16);
        queue_pixel(16'h0100, 1'b0);
        queue_pixel(16'h00FF, 1'b0);
        queue_pixel(16'hFF00, 1'b1);
        drain();

        set_format(FMT_LE16_ALT);
        queue_pixel(16'h8001, 1'b0);
        queue_pixel(16'h7FFE, 1'b1);
        drain();

        // Format switch in the middle of a row
        set_format(FMT_LE16);
        queue_pixel(16'h0102, 1'b0);
        queue_pixel(16'h0304, 1'b0);
        drain();
        set_format(FMT_BE16);
        queue_pixel(16'h0506, 1'b1);
        drain();

        // Random rows, one format per phase; last phase runs without idling
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       fmt = FMT_GRAY8;
                1:       fmt = FMT_LE16;
                2:       fmt = FMT_BE16;
                3:       fmt = FMT_LE16_ALT;
                default: fmt = FMT_W'($urandom_range(0, 3));
            endcase
            set_format(fmt);
            if (ph == RANDOM_PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            end
            // full-width row at maximum swing, then a row past the maximum width
            if (ph == 1) begin
                queue_row(ROW_MAX, ROW_ZIGZAG);
                queue_row(ROW_MAX + 1 + $urandom_range(0, 3), ROW_NOISE);
            end
            fill = 0;
            while (fill < PHASE_PIXELS) begin
                case ($urandom_range(0, 9))
                    0:       len = 1;
                    9:       len = $urandom_range(17, 64);
                    default: len = $urandom_range(2, 16);
                endcase
                case ($urandom_range(0, 9))
                    4, 5:    style = ROW_NEAR;
                    6:       style = ROW_FLAT;
                    7:       style = ROW_DARK;
                    8:       style = ROW_EXTREME;
                    default: style = ROW_NOISE;
                endcase
                queue_row(len, style);
                fill += len;
            end
            // receiver holds off while many short rows are still queued
            if (ph == 2)
                hold_request = 1'b1;
            drain();
        end

        if (fails == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/rcdm_pkg.sv
rtl/core/row_column_difference_metric.sv
rtl/core/rcdm_chk.sv
dv/testbench.sv
